FILE: src/bcfa_pkg.sv
// bcfa_pkg: shared types and constants of the contiguous frame allocator
// used by bcfa_byte_scan and bitmap_contiguous_frame_allocator; no dependencies
package bcfa_pkg;

  // frame numbers on the ports never reach beyond this many frames
  localparam int MAX_FRAMES = 32768;
  // width of a frame number that can hold MAX_FRAMES itself
  localparam int FRAME_W = 16;
  // width of a byte index that can hold MAX_FRAMES / 8 itself
  localparam int BYTE_W = 13;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic {
    ST_OK   = 1'b0,
    ST_FAIL = 1'b1
  } status_t;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_MARK   = 6'b001000,
    S_REL_RD = 6'b010000,
    S_REL_WR = 6'b100000
  } state_t;

  // outcome of scanning one bitmap byte
  typedef struct packed {
    logic               found;
    logic [FRAME_W-1:0] run;
    logic [14:0]        base;
    logic [14:0]        last;
  } scan_res_t;

endpackage

FILE: src/bitmap_contiguous_frame_allocator.sv
// bitmap_contiguous_frame_allocator: first-fit contiguous page-frame allocator
// Channels: a command is taken on a clock edge with start high and busy low.
//   opcode 0 allocates frame_count free frames inside [window_start, window_end),
//   below frame_limit and NUM_FRAMES; opcode 1 frees release_frame.
//   Each command gives one result beat: done is high for one cycle with status
//   and base_frame; the receiver cannot stall, so the beat is taken that cycle.
//   cfg_valid/cfg_data write frame_limit; cfg_ready is always high, and writes
//   are meant for times when the block is idle.
// Operation: the bitmap lives in a byte-wide memory with one read port and one
//   write port. A free of a frame in range reads its byte and writes it back
//   with that bit cleared. An allocate reads one bitmap byte per cycle from
//   window_start / 8 until a run fits or the window ends, then rewrites the
//   bytes the run covers one per cycle; a zero count fails without a search.
//   Commands are handled one at a time; busy is high until the result beat.
// Reset: rst is synchronous. After reset the block writes zero to every bitmap
//   byte, one per cycle, with busy high; config writes are taken during that
//   time. frame_limit resets to 32768.
// Depends on bcfa_pkg, bcfa_bitmap_ram and bcfa_byte_scan.
module bitmap_contiguous_frame_allocator
  import bcfa_pkg::*;
#(
  parameter int NUM_FRAMES = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [14:0] window_start,
  input  logic [15:0] window_end,
  input  logic [15:0] frame_count,
  input  logic [14:0] release_frame,
  output logic        done,
  output logic        status,
  output logic [14:0] base_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int DEPTH     = (NUM_FRAMES + 7) / 8;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FRAME_CAP = (NUM_FRAMES > MAX_FRAMES) ? MAX_FRAMES : NUM_FRAMES;

  state_t             state;
  logic [15:0]        frame_limit;
  logic [AW-1:0]      clr_addr;
  logic [14:0]        win_start;
  logic [FRAME_W-1:0] hi;
  logic [FRAME_W-1:0] count;
  logic [14:0]        rel;
  logic [BYTE_W-1:0]  rd_ptr;
  logic [BYTE_W-1:0]  ev_ptr;
  logic               ev_valid;
  logic [FRAME_W-1:0] run;
  logic [14:0]        base;
  logic [14:0]        last;
  logic [BYTE_W-1:0]  mk_ptr;
  logic [BYTE_W-1:0]  mk_end;
  logic [BYTE_W-1:0]  wr_ptr;
  logic               wr_valid;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [7:0]         rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [7:0]         wr_data;

  logic [FRAME_W-1:0] lim_in;
  logic [FRAME_W-1:0] hi_in;
  logic               scan_more;
  logic               mk_more;
  logic [7:0]         mark_mask;
  scan_res_t          sr;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // search bound of a new command
  assign lim_in    = (frame_limit < window_end) ? frame_limit : window_end;
  assign hi_in     = (FRAME_W'(FRAME_CAP) < lim_in) ? FRAME_W'(FRAME_CAP) : lim_in;
  assign scan_more = ({rd_ptr, 3'b000} < hi);
  assign mk_more   = (mk_ptr <= mk_end);

  // bits of the byte being marked that fall inside the run
  always_comb begin
    logic [FRAME_W-1:0] f;
    for (int i = 0; i < 8; i++) begin
      f = {wr_ptr, 3'(i)};
      mark_mask[i] = (f >= {1'b0, base}) && (f <= {1'b0, last});
    end
  end

  bcfa_bitmap_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bcfa_byte_scan u_scan (
    .byte_ptr  (ev_ptr),
    .byte_data (rd_data),
    .win_start (win_start),
    .hi        (hi),
    .count     (count),
    .run_in    (run),
    .base_in   (base),
    .res       (sr)
  );

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      S_SCAN: begin
        rd_en   = scan_more;
        rd_addr = AW'(rd_ptr);
      end
      S_MARK: begin
        rd_en   = mk_more;
        rd_addr = AW'(mk_ptr);
        wr_en   = wr_valid;
        wr_addr = AW'(wr_ptr);
        wr_data = rd_data | mark_mask;
      end
      S_REL_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(rel[14:3]);
      end
      S_REL_WR: begin
        wr_en   = 1'b1;
        wr_addr = AW'(rel[14:3]);
        wr_data = rd_data & ~(8'b0000_0001 << rel[2:0]);
      end
      default: begin
      end
    endcase
  end

  // frame limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= 16'(MAX_FRAMES);
    end else if (cfg_valid && cfg_ready) begin
      frame_limit <= cfg_data;
    end
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
      ev_valid <= 1'b0;
      wr_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            win_start <= window_start;
            hi        <= hi_in;
            count     <= frame_count;
            rel       <= release_frame;
            rd_ptr    <= BYTE_W'(window_start[14:3]);
            run       <= '0;
            base      <= '0;
            ev_valid  <= 1'b0;
            wr_valid  <= 1'b0;
            if (opcode == OP_RELEASE) begin
              if ({1'b0, release_frame} < FRAME_W'(FRAME_CAP)) begin
                state <= S_REL_RD;
              end else begin
                done       <= 1'b1;
                status     <= ST_OK;
                base_frame <= '0;
              end
            end else if (frame_count == '0) begin
              done       <= 1'b1;
              status     <= ST_FAIL;
              base_frame <= '0;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_more) begin
            rd_ptr <= rd_ptr + 1'b1;
            ev_ptr <= rd_ptr;
          end
          ev_valid <= scan_more;
          if (ev_valid) begin
            run  <= sr.run;
            base <= sr.base;
            if (sr.found) begin
              last     <= sr.last;
              mk_ptr   <= BYTE_W'(sr.base[14:3]);
              mk_end   <= BYTE_W'(sr.last[14:3]);
              wr_valid <= 1'b0;
              state    <= S_MARK;
            end
          end else if (!scan_more) begin
            done       <= 1'b1;
            status     <= ST_FAIL;
            base_frame <= '0;
            state      <= S_IDLE;
          end
        end
        S_MARK: begin
          if (mk_more) begin
            mk_ptr <= mk_ptr + 1'b1;
            wr_ptr <= mk_ptr;
          end
          wr_valid <= mk_more;
          if (!mk_more && !wr_valid) begin
            done       <= 1'b1;
            status     <= ST_OK;
            base_frame <= base;
            state      <= S_IDLE;
          end
        end
        S_REL_RD: begin
          state <= S_REL_WR;
        end
        S_REL_WR: begin
          done       <= 1'b1;
          status     <= ST_OK;
          base_frame <= '0;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a result beat only comes out when the block is ready for the next command
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  // marking never reads and writes the same bitmap byte in one cycle
  a_rmw_apart: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK && wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write of the same byte while marking");

  // a byte is only evaluated in the cycle after its read was issued
  a_scan_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && ev_valid) |-> $past(rd_en))
    else $error("scan evaluates a byte that was not read");

endmodule

FILE: src/bcfa_bitmap_ram.sv
// bcfa_bitmap_ram: usage bitmap storage, one byte per eight frames
// one write port, one read port with registered data; no dependencies
module bcfa_bitmap_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/bcfa_byte_scan.sv
// bcfa_byte_scan: first-fit run tracking over the eight frames of one bitmap byte
// depends on bcfa_pkg for scan_res_t and widths
module bcfa_byte_scan
  import bcfa_pkg::*;
(
  input  logic [BYTE_W-1:0]  byte_ptr,
  input  logic [7:0]         byte_data,
  input  logic [14:0]        win_start,
  input  logic [FRAME_W-1:0] hi,
  input  logic [FRAME_W-1:0] count,
  input  logic [FRAME_W-1:0] run_in,
  input  logic [14:0]        base_in,
  output scan_res_t          res
);

  // walk the eight frames, lowest first, stopping at the first fit
  always_comb begin
    logic [FRAME_W-1:0] f;
    res.found = 1'b0;
    res.run   = run_in;
    res.base  = base_in;
    res.last  = '0;
    for (int i = 0; i < 8; i++) begin
      f = {byte_ptr, 3'(i)};
      if (!res.found && f >= {1'b0, win_start} && f < hi) begin
        if (byte_data[i]) begin
          res.run = '0;
        end else begin
          if (res.run == '0) begin
            res.base = f[14:0];
          end
          res.run = res.run + 1'b1;
          if (res.run == count) begin
            res.found = 1'b1;
            res.last  = f[14:0];
          end
        end
      end
    end
  end

endmodule
